### src/svoc_pkg.sv
package svoc_pkg;

    localparam int DEF_NUM_CHANNELS = 2;
    localparam int DEF_NUM_SOUNDS   = 6;

    localparam int LEN_W   = 24;
    localparam int PRIO_W  = 8;
    localparam int SOUND_W = 4;
    localparam int TICK_W  = 16;

    // One playback channel as it travels around the ring
    typedef struct packed {
        logic [LEN_W-1:0]   len;
        logic [LEN_W-1:0]   pos;
        logic [PRIO_W-1:0]  prio;
        logic [SOUND_W-1:0] sound;
    } chan_t;

    typedef enum logic [1:0] {
        ST_PLAYED  = 2'd0,
        ST_DROPPED = 2'd1,
        ST_IGNORED = 2'd2,
        ST_MIX     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE  = 2'd0,
        FSM_SCAN  = 2'd1,
        FSM_WRITE = 2'd2,
        FSM_TICK  = 2'd3
    } fsm_t;

endpackage

### src/sound_voice_allocator.sv
// An ignored play request answers in the cycle after start, without going busy; a played
// or dropped request answers once the SCAN pass has visited every channel; a mix tick gives
// one word per cycle during its TICK pass. Busy covers the SCAN and WRITE passes for a
// played request, the SCAN pass for a drop and the TICK pass for a tick, and never an
// ignored request; each pass is one full rotation of the channel ring.
// Reset clears all channels and sets sound_enable; the receiver cannot stall results.
module sound_voice_allocator #(
    parameter int NUM_CHANNELS = svoc_pkg::DEF_NUM_CHANNELS,
    parameter int NUM_SOUNDS   = svoc_pkg::DEF_NUM_SOUNDS
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    // command side
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [3:0]  sound_id,
    input  logic [7:0]  sound_priority,
    input  logic [23:0] sound_length,
    input  logic [15:0] tick_bytes,
    // result side
    output logic        done,
    output logic [1:0]  status,
    output logic        channel,
    output logic [3:0]  playing_sound,
    output logic [23:0] play_offset,
    output logic [15:0] play_amount,
    output logic        last
);

    localparam int CNT_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(NUM_CHANNELS - 1);

    // ------------------------------------------------------------------
    // Channel ring: cell 0 is the head, each cell takes its record from the
    // next one up, and the top cell takes the (possibly updated) head record.
    // NUM_CHANNELS shifts bring every channel back to its home cell.
    // ------------------------------------------------------------------
    svoc_pkg::chan_t                 rec_q [NUM_CHANNELS];
    logic [svoc_pkg::LEN_W-1:0]      rem_q [NUM_CHANNELS];
    svoc_pkg::chan_t                 feed;
    logic                            shift_en;

    for (genvar i = 0; i < NUM_CHANNELS; i++)
    begin : g_ring
        if (i == NUM_CHANNELS - 1)
        begin : g_top
            svoc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .rec_in   (feed),
                .rec_out  (rec_q[i]),
                .rem_out  (rem_q[i])
            );
        end
        else
        begin : g_mid
            svoc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .rec_in   (rec_q[i+1]),
                .rec_out  (rec_q[i]),
                .rem_out  (rem_q[i])
            );
        end
    end

    // ------------------------------------------------------------------
    // Control and request registers
    // ------------------------------------------------------------------
    svoc_pkg::fsm_t   state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] slot_reg, slot_next;
    logic             found_reg, found_next;
    logic [CNT_W-1:0] best_idx_reg, best_idx_next;
    logic [8:0]       best_prio_reg, best_prio_next;   // 256 means no candidate yet
    logic [23:0]      best_rem_reg, best_rem_next;
    logic [3:0]       best_sound_reg, best_sound_next;
    logic             sound_enable_reg;

    logic [3:0]       id_reg, id_next;
    logic [7:0]       prio_reg, prio_next;
    logic [23:0]      len_reg, len_next;
    logic [15:0]      tick_reg, tick_next;

    // output word
    logic             done_reg, done_next;
    svoc_pkg::status_t status_reg, status_next;
    logic             channel_reg, channel_next;
    logic [3:0]       sound_reg, sound_next;
    logic [23:0]      offset_reg, offset_next;
    logic [15:0]      amount_reg, amount_next;
    logic             last_reg, last_next;

    svoc_pkg::chan_t  head;
    logic [23:0]      head_rem;
    logic [15:0]      amt;
    logic             at_last;
    logic             better;
    logic             id_ok;

    assign head     = rec_q[0];
    assign head_rem = rem_q[0];
    assign at_last  = (idx_reg == LAST_IDX);
    assign amt      = (head_rem < {8'd0, tick_reg}) ? head_rem[15:0] : tick_reg;
    assign id_ok    = ({1'b0, sound_id} < 5'(NUM_SOUNDS));
    assign better   = ({1'b0, head.prio} < best_prio_reg) ||
                      (({1'b0, head.prio} == best_prio_reg) && (head_rem < best_rem_reg));
    assign shift_en = (state_reg != svoc_pkg::FSM_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        slot_next       = slot_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_prio_next  = best_prio_reg;
        best_rem_next   = best_rem_reg;
        best_sound_next = best_sound_reg;
        id_next         = id_reg;
        prio_next       = prio_reg;
        len_next        = len_reg;
        tick_next       = tick_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        channel_next    = channel_reg;
        sound_next      = sound_reg;
        offset_next     = offset_reg;
        amount_next     = amount_reg;
        last_next       = last_reg;
        feed            = head;

        case (state_reg)
            svoc_pkg::FSM_IDLE:
            begin
                if (start)
                begin
                    idx_next       = '0;
                    id_next        = sound_id;
                    prio_next      = sound_priority;
                    len_next       = sound_length;
                    tick_next      = tick_bytes;
                    found_next     = 1'b0;
                    best_prio_next = 9'd256;
                    best_rem_next  = '0;
                    best_idx_next  = '0;
                    if (req_type)
                    begin
                        state_next = svoc_pkg::FSM_TICK;
                    end
                    else if (!sound_enable_reg || !id_ok)
                    begin
                        // ignored: answer at once, channels untouched
                        done_next    = 1'b1;
                        status_next  = svoc_pkg::ST_IGNORED;
                        channel_next = 1'b0;
                        sound_next   = '0;
                        offset_next  = '0;
                        amount_next  = '0;
                        last_next    = 1'b1;
                    end
                    else
                    begin
                        state_next = svoc_pkg::FSM_SCAN;
                    end
                end
            end

            svoc_pkg::FSM_SCAN:
            begin
                // first finished channel wins; otherwise track the weakest one
                if (!found_reg)
                begin
                    if (head_rem == '0)
                    begin
                        found_next = 1'b1;
                        slot_next  = idx_reg;
                    end
                    else if (better)
                    begin
                        best_prio_next  = {1'b0, head.prio};
                        best_rem_next   = head_rem;
                        best_idx_next   = idx_reg;
                        best_sound_next = head.sound;
                    end
                end
                idx_next = idx_reg + 1'b1;
                if (at_last)
                begin
                    idx_next    = '0;
                    done_next   = 1'b1;
                    offset_next = '0;
                    amount_next = '0;
                    last_next   = 1'b1;
                    if (!found_next && ({1'b0, prio_reg} < best_prio_next))
                    begin
                        // every channel busy and stronger: drop
                        state_next   = svoc_pkg::FSM_IDLE;
                        status_next  = svoc_pkg::ST_DROPPED;
                        channel_next = best_idx_next[0];
                        sound_next   = best_sound_next;
                    end
                    else
                    begin
                        if (!found_next)
                        begin
                            slot_next = best_idx_next;
                        end
                        state_next   = svoc_pkg::FSM_WRITE;
                        status_next  = svoc_pkg::ST_PLAYED;
                        channel_next = found_next ? slot_next[0] : best_idx_next[0];
                        sound_next   = id_reg;
                    end
                end
            end

            svoc_pkg::FSM_WRITE:
            begin
                // replace the chosen channel as it passes the head
                if (idx_reg == slot_reg)
                begin
                    feed.len   = len_reg;
                    feed.pos   = '0;
                    feed.prio  = prio_reg;
                    feed.sound = id_reg;
                end
                idx_next = idx_reg + 1'b1;
                if (at_last)
                begin
                    idx_next   = '0;
                    state_next = svoc_pkg::FSM_IDLE;
                end
            end

            svoc_pkg::FSM_TICK:
            begin
                // advance the head channel and report its portion
                feed.pos     = head.pos + {8'd0, amt};
                done_next    = 1'b1;
                status_next  = svoc_pkg::ST_MIX;
                channel_next = idx_reg[0];
                sound_next   = head.sound;
                offset_next  = head.pos;
                amount_next  = amt;
                last_next    = at_last;
                idx_next     = idx_reg + 1'b1;
                if (at_last)
                begin
                    idx_next   = '0;
                    state_next = svoc_pkg::FSM_IDLE;
                end
            end

            default:
            begin
                state_next = svoc_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= svoc_pkg::FSM_IDLE;
            idx_reg          <= '0;
            slot_reg         <= '0;
            found_reg        <= 1'b0;
            best_idx_reg     <= '0;
            best_prio_reg    <= 9'd256;
            best_rem_reg     <= '0;
            done_reg         <= 1'b0;
            sound_enable_reg <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            slot_reg      <= slot_next;
            found_reg     <= found_next;
            best_idx_reg  <= best_idx_next;
            best_prio_reg <= best_prio_next;
            best_rem_reg  <= best_rem_next;
            done_reg      <= done_next;
            if (cfg_we)
            begin
                sound_enable_reg <= cfg_wdata;
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        best_sound_reg <= best_sound_next;
        id_reg         <= id_next;
        prio_reg       <= prio_next;
        len_reg        <= len_next;
        tick_reg       <= tick_next;
        status_reg     <= status_next;
        channel_reg    <= channel_next;
        sound_reg      <= sound_next;
        offset_reg     <= offset_next;
        amount_reg     <= amount_next;
        last_reg       <= last_next;
    end

    assign busy          = (state_reg != svoc_pkg::FSM_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign channel       = channel_reg;
    assign playing_sound = sound_reg;
    assign play_offset   = offset_reg;
    assign play_amount   = amount_reg;
    assign last          = last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ignore_when_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !req_type && !sound_enable_reg
        |=> done && status == svoc_pkg::ST_IGNORED && last)
        else $error("disabled play request not ignored");

    a_request_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != svoc_pkg::ST_MIX |-> last)
        else $error("play request word without last");

    a_tick_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req_type |=> busy && state_reg == svoc_pkg::FSM_TICK)
        else $error("mix tick did not start a pass");

    a_write_after_play: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == svoc_pkg::FSM_SCAN && state_next == svoc_pkg::FSM_WRITE
        |=> done && status == svoc_pkg::ST_PLAYED)
        else $error("channel write without played word");

endmodule

### src/svoc_cell.sv
module svoc_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift_en,
    input  svoc_pkg::chan_t      rec_in,
    output svoc_pkg::chan_t      rec_out,
    output logic [svoc_pkg::LEN_W-1:0] rem_out
);

    svoc_pkg::chan_t rec_reg;
    svoc_pkg::chan_t rec_next;

    always_comb
    begin
        rec_next = rec_reg;
        if (shift_en)
        begin
            rec_next = rec_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else
        begin
            rec_reg <= rec_next;
        end
    end

    // bytes left to play; a position past the end counts as finished
    assign rem_out = (rec_reg.pos >= rec_reg.len) ? '0 : (rec_reg.len - rec_reg.pos);
    assign rec_out = rec_reg;

endmodule
